// ----- hdl/skfti_pkg.sv -----
package skfti_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int KEY_W       = 16;
    localparam int VAL_W       = 32;
    localparam int SLOT_W      = 4;
    localparam int ENTRIES_W   = 5;
    localparam int TOL_W       = 16;
    localparam int ADDR_W      = 3;
    localparam int DATA_W      = 32;

    localparam logic [TOL_W-1:0]     TOL_RESET     = 16'd128;
    localparam logic [ENTRIES_W-1:0] ENTRIES_RESET = 5'd10;

    localparam logic OP_SET  = 1'b0;
    localparam logic OP_READ = 1'b1;

    // register index, taken from paddr[2]
    localparam logic REG_MERGE_TOL = 1'b0;
    localparam logic REG_ENTRIES   = 1'b1;

    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_REPLACED = 2'd1,
        ST_DROPPED  = 2'd2,
        ST_READ     = 2'd3
    } t_status;

    typedef struct packed {
        logic [TOL_W-1:0]     merge_tol;
        logic [ENTRIES_W-1:0] entries;
    } t_cfg;

    // handed from cell i to cell i+1
    typedef struct packed {
        logic                    found;  // some earlier cell matched
        logic                    shift;  // an insert happened earlier: move down
        logic [KEY_W-1:0]        key;
        logic signed [VAL_W-1:0] value;
    } t_link;

endpackage

// ----- hdl/skfti_if.sv -----
interface skfti_in_if import skfti_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic                    op;
    logic [KEY_W-1:0]        key;
    logic signed [VAL_W-1:0] frame_value;
    logic [SLOT_W-1:0]       read_slot;

    modport source (output valid, op, key, frame_value, read_slot, input ready);
    modport sink   (input valid, op, key, frame_value, read_slot, output ready);
endinterface

interface skfti_out_if import skfti_pkg::*; ();
    logic                    valid;
    logic                    ready;
    t_status                 status;
    logic [SLOT_W-1:0]       position;
    logic [KEY_W-1:0]        entry_key;
    logic signed [VAL_W-1:0] entry_value;

    modport source (output valid, status, position, entry_key, entry_value, input ready);
    modport sink   (input valid, status, position, entry_key, entry_value, output ready);
endinterface

// ----- hdl/sorted_keyframe_table_insert_top.sv -----
// Sorted key/value table with insert-or-merge and slot reads, one result per item.
// The result is valid in the output register in the cycle after the input transfer.
// Throughput: 1 item per cycle while results are taken; the path that sets the
//   clock is the first-hit ripple through the row of TABLE_DEPTH cells.
// Reset: synchronous active low; table cleared to zero in the reset cycle,
//   registers return to merge_tolerance 128 and entries_in_use 10.
module sorted_keyframe_table_insert_top import skfti_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    skfti_in_if.sink          in_ch,
    skfti_out_if.source       out_ch,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    t_cfg w_cfg;

    // configuration registers
    skfti_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // handshake: the output register frees up when its result is taken
    logic r_out_valid;
    logic w_in_ready;
    logic w_xfer;
    logic w_upd;

    assign w_in_ready  = !r_out_valid || out_ch.ready;
    assign in_ch.ready = w_in_ready;
    assign w_xfer      = in_ch.valid && w_in_ready;
    assign w_upd       = w_xfer && (in_ch.op == OP_SET);

    // cell row; link[i] feeds cell i, cell 0 sees nothing before it
    t_link                   w_link [TABLE_DEPTH+1];
    logic [TABLE_DEPTH-1:0]  w_first;
    logic [TABLE_DEPTH-1:0]  w_merge;
    logic [TABLE_DEPTH-1:0]  w_in_use;
    logic [TABLE_DEPTH-1:0]  w_rsel;
    logic [KEY_W-1:0]        w_cell_key [TABLE_DEPTH];
    logic signed [VAL_W-1:0] w_cell_val [TABLE_DEPTH];

    assign w_link[0] = '0;

    genvar g;
    generate
        for (g = 0; g < TABLE_DEPTH; g++) begin : g_cell
            // zero slots in use acts as one; above depth is simply all cells
            assign w_in_use[g] = (g == 0) || (32'(g) < 32'(w_cfg.entries));
            assign w_rsel[g]   = (32'(in_ch.read_slot) == 32'(g));

            skfti_cell u_cell (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_upd    (w_upd),
                .i_in_use (w_in_use[g]),
                .i_key    (in_ch.key),
                .i_value  (in_ch.frame_value),
                .i_tol    (w_cfg.merge_tol),
                .i_prev   (w_link[g]),
                .o_next   (w_link[g+1]),
                .o_first  (w_first[g]),
                .o_merge  (w_merge[g]),
                .o_key    (w_cell_key[g]),
                .o_value  (w_cell_val[g])
            );
        end
    endgenerate

    // one-hot selects: the first-hit cell for a set, the addressed cell for a read.
    // The read slot is SLOT_W bits wide, so every read addresses one of the TABLE_DEPTH cells.
    logic [KEY_W-1:0]        w_hit_key;
    logic [SLOT_W-1:0]       w_hit_pos;
    logic [KEY_W-1:0]        w_rd_key;
    logic signed [VAL_W-1:0] w_rd_val;
    logic                    w_sorted;

    always_comb begin
        w_hit_key = '0;
        w_hit_pos = '0;
        w_rd_key  = '0;
        w_rd_val  = '0;
        w_sorted  = 1'b1;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (w_first[i]) begin
                w_hit_key = w_hit_key | w_cell_key[i];
                w_hit_pos = w_hit_pos | SLOT_W'(i);
            end
            if (w_rsel[i]) begin
                w_rd_key = w_rd_key | w_cell_key[i];
                w_rd_val = w_rd_val | w_cell_val[i];
            end
            if (i > 0) begin
                if (w_cell_key[i] > w_cell_key[i-1]) begin
                    w_sorted = 1'b0;
                end
            end
        end
    end

    // result register
    t_status                 n_status;
    logic [SLOT_W-1:0]       n_pos;
    logic [KEY_W-1:0]        n_key;
    logic signed [VAL_W-1:0] n_val;
    t_status                 r_status;
    logic [SLOT_W-1:0]       r_pos;
    logic [KEY_W-1:0]        r_key;
    logic signed [VAL_W-1:0] r_val;

    always_comb begin
        if (in_ch.op == OP_READ) begin
            n_status = ST_READ;
            n_pos    = in_ch.read_slot;
            n_key    = w_rd_key;
            n_val    = w_rd_val;
        end else if (!w_link[TABLE_DEPTH].found) begin
            // key below every entry in use
            n_status = ST_DROPPED;
            n_pos    = '0;
            n_key    = '0;
            n_val    = '0;
        end else if (|w_merge) begin
            n_status = ST_REPLACED;
            n_pos    = w_hit_pos;
            n_key    = w_hit_key;
            n_val    = in_ch.frame_value;
        end else begin
            n_status = ST_INSERTED;
            n_pos    = w_hit_pos;
            n_key    = in_ch.key;
            n_val    = in_ch.frame_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_xfer) begin
            r_out_valid <= 1'b1;
        end else if (out_ch.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_xfer) begin
            r_status <= n_status;
            r_pos    <= n_pos;
            r_key    <= n_key;
            r_val    <= n_val;
        end
    end

    assign out_ch.valid       = r_out_valid;
    assign out_ch.status      = r_status;
    assign out_ch.position    = r_pos;
    assign out_ch.entry_key   = r_key;
    assign out_ch.entry_value = r_val;

    // checks
    a_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n) w_sorted)
        else $error("table keys not in descending order");

    a_one_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_first))
        else $error("more than one insert point");

    a_xfer_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_xfer |=> r_out_valid)
        else $error("input transfer without a result");

    a_rst_idle: assert property (@(posedge i_clk) !i_rst_n |=> !r_out_valid)
        else $error("result valid after reset");

endmodule

// ----- hdl/skfti_cfg.sv -----
module skfti_cfg import skfti_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    logic [TOL_W-1:0]     r_merge_tol;
    logic [ENTRIES_W-1:0] r_entries;
    logic                 w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_merge_tol <= TOL_RESET;
            r_entries   <= ENTRIES_RESET;
        end else if (w_wr) begin
            case (paddr[2])
                REG_MERGE_TOL: r_merge_tol <= pwdata[TOL_W-1:0];
                REG_ENTRIES:   r_entries   <= pwdata[ENTRIES_W-1:0];
                default:       ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_MERGE_TOL: prdata = {{(DATA_W-TOL_W){1'b0}}, r_merge_tol};
            REG_ENTRIES:   prdata = {{(DATA_W-ENTRIES_W){1'b0}}, r_entries};
            default:       prdata = '0;
        endcase
    end

    assign o_cfg.merge_tol = r_merge_tol;
    assign o_cfg.entries   = r_entries;

endmodule

// ----- hdl/skfti_cell.sv -----
module skfti_cell import skfti_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_upd,      // set item transferred this cycle
    input  logic                    i_in_use,
    input  logic [KEY_W-1:0]        i_key,
    input  logic signed [VAL_W-1:0] i_value,
    input  logic [TOL_W-1:0]        i_tol,
    input  t_link                   i_prev,
    output t_link                   o_next,
    output logic                    o_first,
    output logic                    o_merge,
    output logic [KEY_W-1:0]        o_key,
    output logic signed [VAL_W-1:0] o_value
);

    logic [KEY_W-1:0]        r_key;
    logic signed [VAL_W-1:0] r_value;
    logic [KEY_W-1:0]        n_key;
    logic signed [VAL_W-1:0] n_value;
    logic                    w_hit;
    logic [KEY_W-1:0]        w_diff;

    // table is sorted descending, so the first hit is the insert point
    assign w_hit   = i_in_use && ((r_key == '0) || (i_key >= r_key));
    assign o_first = w_hit && !i_prev.found;
    assign w_diff  = i_key - r_key;
    assign o_merge = o_first && (r_key != '0) && (w_diff < i_tol);

    assign o_next.found = i_prev.found || w_hit;
    assign o_next.shift = i_prev.shift || (o_first && !o_merge);
    assign o_next.key   = r_key;
    assign o_next.value = r_value;

    always_comb begin
        n_key   = r_key;
        n_value = r_value;
        if (o_merge) begin
            n_value = i_value;
        end else if (o_first) begin
            n_key   = i_key;
            n_value = i_value;
        end else if (i_prev.shift && i_in_use) begin
            n_key   = i_prev.key;
            n_value = i_prev.value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key   <= '0;
            r_value <= '0;
        end else if (i_upd) begin
            r_key   <= n_key;
            r_value <= n_value;
        end
    end

    assign o_key   = r_key;
    assign o_value = r_value;

endmodule

// ----- tb/tb.sv -----
module tb;
    import skfti_pkg::*;

    // one input item and one result, at the block's widths
    typedef struct packed {
        logic                    op;
        logic [KEY_W-1:0]        key;
        logic signed [VAL_W-1:0] value;
        logic [SLOT_W-1:0]       slot;
    } t_frame_item;

    typedef struct packed {
        t_status                 status;
        logic [SLOT_W-1:0]       position;
        logic [KEY_W-1:0]        key;
        logic signed [VAL_W-1:0] value;
    } t_frame_result;

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    skfti_in_if  in_ch ();
    skfti_out_if out_ch ();

    sorted_keyframe_table_insert_top uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // shadow table and registers
    logic [KEY_W-1:0]        shadow_key [TABLE_DEPTH];
    logic signed [VAL_W-1:0] shadow_val [TABLE_DEPTH];
    logic [TOL_W-1:0]        tol_cfg;
    logic [ENTRIES_W-1:0]    slots_cfg;

    t_frame_item   pending_q[$];
    t_frame_result expected_q[$];
    int            items_open;
    int            err_cnt;
    int            n_insert, n_merge, n_drop, n_read, n_settings;

    logic [KEY_W-1:0] key_pool [8];

    // ---------------------------------------------------------------
    // clock and reset
    // ---------------------------------------------------------------
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // table prediction: reads, drops, search, merge or insert with shift-down
    // ---------------------------------------------------------------
    function automatic t_frame_result table_update(t_frame_item it);
        t_frame_result r;
        int            used;
        int            hit;
        int            j;
        r    = '0;
        hit  = -1;
        used = int'(slots_cfg);
        if (used == 0) used = 1;
        if (used > TABLE_DEPTH) used = TABLE_DEPTH;

        if (it.op == OP_READ) begin
            r.status   = ST_READ;
            r.position = it.slot;
            if (int'(it.slot) < TABLE_DEPTH) begin
                r.key   = shadow_key[it.slot];
                r.value = shadow_val[it.slot];
            end
            n_read++;
            return r;
        end

        for (int i = 0; i < used; i++) begin
            if (hit < 0 && (shadow_key[i] == '0 || it.key >= shadow_key[i])) hit = i;
        end

        if (hit < 0) begin
            // key below every entry of a full table
            r.status = ST_DROPPED;
            n_drop++;
        end else if (shadow_key[hit] != '0 &&
                     (int'(it.key) - int'(shadow_key[hit])) < int'(tol_cfg)) begin
            shadow_val[hit] = it.value;
            r.status   = ST_REPLACED;
            r.position = SLOT_W'(hit);
            r.key      = shadow_key[hit];
            r.value    = it.value;
            n_merge++;
        end else begin
            for (j = used - 1; j > hit; j--) begin
                shadow_key[j] = shadow_key[j-1];
                shadow_val[j] = shadow_val[j-1];
            end
            shadow_key[hit] = it.key;
            shadow_val[hit] = it.value;
            r.status   = ST_INSERTED;
            r.position = SLOT_W'(hit);
            r.key      = it.key;
            r.value    = it.value;
            n_insert++;
        end
        return r;
    endfunction

    // ---------------------------------------------------------------
    // input driver: bursts with random gaps, changes on falling edge
    // ---------------------------------------------------------------
    bit          took_item;
    int          burst_left;
    int          gap_left;
    t_frame_item drv_item;

    always @(negedge i_clk) begin
        if (i_rst_n && (!in_ch.valid || took_item)) begin
            took_item = 1'b0;
            if (gap_left > 0) begin
                in_ch.valid <= 1'b0;
                gap_left--;
            end else if (pending_q.size() > 0) begin
                drv_item = pending_q.pop_front();
                in_ch.valid       <= 1'b1;
                in_ch.op          <= drv_item.op;
                in_ch.key         <= drv_item.key;
                in_ch.frame_value <= drv_item.value;
                in_ch.read_slot   <= drv_item.slot;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    // occasional long burst without any gap
                    burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
                                                             : $urandom_range(0, 15);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // result receiver: ready follows an 8-bit mask, reshuffled often
    // ---------------------------------------------------------------
    logic [7:0] ready_mask;
    int         mask_age;
    int         rx_cyc;

    always @(negedge i_clk) begin
        if (mask_age == 0) begin
            ready_mask = ($urandom_range(0, 3) == 0) ? 8'hFF : (8'($urandom) | 8'h01);
            mask_age   = $urandom_range(16, 64);
        end
        mask_age--;
        rx_cyc++;
        out_ch.ready <= ready_mask[3'(rx_cyc)];
    end

    // ---------------------------------------------------------------
    // monitor: check results, then predict for accepted inputs
    // ---------------------------------------------------------------
    t_frame_result want;
    t_frame_item   seen;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                if (expected_q.size() == 0) begin
                    $error("result transfer with nothing expected: status %0d pos %0d",
                           out_ch.status, out_ch.position);
                    err_cnt++;
                end else begin
                    want = expected_q.pop_front();
                    if (out_ch.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, out_ch.status);
                        err_cnt++;
                    end
                    if (out_ch.position !== want.position) begin
                        $error("position: expected %0d, got %0d",
                               want.position, out_ch.position);
                        err_cnt++;
                    end
                    if (out_ch.entry_key !== want.key) begin
                        $error("entry_key: expected %h, got %h", want.key, out_ch.entry_key);
                        err_cnt++;
                    end
                    if (out_ch.entry_value !== want.value) begin
                        $error("entry_value: expected %h, got %h",
                               want.value, out_ch.entry_value);
                        err_cnt++;
                    end
                end
            end
            if (in_ch.valid && in_ch.ready) begin
                seen = '{op: in_ch.op, key: in_ch.key, value: in_ch.frame_value,
                         slot: in_ch.read_slot};
                expected_q.push_back(table_update(seen));
                items_open--;
                took_item = 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------
    function automatic t_frame_item set_item(logic [KEY_W-1:0] k, logic [VAL_W-1:0] v);
        set_item = '{op: OP_SET, key: k, value: v, slot: 4'($urandom)};
    endfunction

    function automatic t_frame_item read_item(logic [SLOT_W-1:0] s);
        read_item = '{op: OP_READ, key: 16'($urandom), value: $urandom, slot: s};
    endfunction

    task automatic queue_item(t_frame_item it);
        pending_q.push_back(it);
        items_open++;
    endtask

    task automatic wait_drained();
        do @(negedge i_clk); while (items_open != 0 || expected_q.size() != 0);
        repeat (3) @(negedge i_clk);
    endtask

    task automatic write_register(logic idx, logic [DATA_W-1:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (idx == REG_MERGE_TOL) tol_cfg = data[TOL_W-1:0];
        else                      slots_cfg = data[ENTRIES_W-1:0];
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apply_settings(logic [TOL_W-1:0] tol, logic [ENTRIES_W-1:0] used);
        write_register(REG_MERGE_TOL, DATA_W'(tol));
        write_register(REG_ENTRIES, DATA_W'(used));
        n_settings++;
    endtask

    // random items: mostly sets clustered around a pool of keys so that
    // merges, shifts and drops from a full table happen often
    task automatic run_random(int count);
        t_frame_item      it;
        int               sel;
        logic [KEY_W-1:0] k;
        logic [VAL_W-1:0] v;
        for (int p = 0; p < 8; p++) key_pool[p] = 16'($urandom);
        for (int n = 0; n < count; n++) begin
            case ($urandom_range(0, 9))
                0:       v = 32'h7FFF_FFFF;
                1:       v = 32'h8000_0000;
                2:       v = 32'h0;
                3:       v = 32'hFFFF_FFFF;
                default: v = $urandom;
            endcase
            sel = $urandom_range(0, 19);
            if (sel == 0)      k = '0;
            else if (sel == 1) k = 16'hFFFF;
            else if (sel == 2) k = 16'h0001;
            else if (sel < 11) k = key_pool[$urandom_range(0, 7)] + 16'($urandom_range(0, 400));
            else               k = 16'($urandom);
            if ($urandom_range(0, 3) == 0) it = read_item(4'($urandom));
            else                           it = set_item(k, v);
            queue_item(it);
        end
        wait_drained();
    endtask

    // ---------------------------------------------------------------
    // test sequence
    // ---------------------------------------------------------------
    logic [TOL_W-1:0]     rnd_tol;
    logic [ENTRIES_W-1:0] rnd_used;

    initial begin
        i_rst_n           = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        in_ch.valid       = 1'b0;
        in_ch.op          = OP_SET;
        in_ch.key         = '0;
        in_ch.frame_value = '0;
        in_ch.read_slot   = '0;
        out_ch.ready      = 1'b0;
        tol_cfg           = TOL_RESET;
        slots_cfg         = ENTRIES_RESET;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            shadow_key[i] = '0;
            shadow_val[i] = '0;
        end
        items_open = 0;
        err_cnt    = 0;
        burst_left = 0;
        gap_left   = 0;
        mask_age   = 0;
        rx_cyc     = 0;
        took_item  = 1'b0;
        n_settings = 1;

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed, reset settings (tolerance 128, ten slots)
        queue_item(read_item(4'd0));                    // cleared table
        queue_item(read_item(4'd15));                   // last slot
        queue_item(set_item(16'h0100, 32'h0000_0001));  // insert into empty table
        queue_item(set_item(16'h0150, 32'h0000_0002));  // within tolerance: merge
        queue_item(set_item(16'h0180, 32'h0000_0003));  // distance equals tolerance: insert
        queue_item(set_item(16'h0080, 32'h0000_0004));  // below all, empty slot takes it
        queue_item(set_item(16'h0000, 32'h1234_5678));  // key zero lands in first empty
        queue_item(set_item(16'h0000, 32'h0BAD_F00D));  // empty slot never merges
        queue_item(set_item(16'hFFFF, 32'h7FFF_FFFF));  // top key, shifts everything down
        queue_item(set_item(16'h0001, 32'h8000_0000));
        queue_item(set_item(16'hFFFF, 32'hFFFF_FFFF));  // exact match: merge
        for (int s = 0; s < 8; s++) queue_item(read_item(SLOT_W'(s)));
        wait_drained();

        // one slot, zero tolerance: drop, and same key inserts again
        apply_settings(16'd0, 5'd1);
        queue_item(set_item(16'hFFFF, 32'h0000_0011));
        queue_item(set_item(16'h0800, 32'h0000_0012));  // below full table: dropped
        queue_item(set_item(16'hFFFF, 32'h0000_0013));  // zero tolerance never merges
        queue_item(read_item(4'd0));
        queue_item(read_item(4'd1));
        wait_drained();
        run_random(150);

        apply_settings(16'hFFFF, 5'd16);                // widest tolerance, whole table
        run_random(200);
        apply_settings(TOL_RESET, 5'd0);                // zero slots acts as one
        run_random(100);
        apply_settings(16'($urandom_range(0, 1023)), 5'd31);  // above depth acts as depth
        run_random(200);

        for (int ph = 0; ph < 8; ph++) begin
            case ($urandom_range(0, 4))
                0:       rnd_tol = 16'd0;
                1:       rnd_tol = 16'hFFFF;
                2:       rnd_tol = 16'($urandom);
                default: rnd_tol = 16'($urandom_range(1, 1023));
            endcase
            rnd_used = ($urandom_range(0, 4) == 0) ? 5'($urandom) : 5'($urandom_range(1, 16));
            apply_settings(rnd_tol, rnd_used);
            run_random(110);
        end

        repeat (10) @(negedge i_clk);
        if (expected_q.size() != 0) begin
            $error("%0d results never arrived", expected_q.size());
            err_cnt++;
        end

        $display("Run covered %0d sets (%0d inserted, %0d merged, %0d dropped) and %0d reads",
                 n_insert + n_merge + n_drop, n_insert, n_merge, n_drop, n_read);
        $display("across %0d register settings, with input gaps and output stalls",
                 n_settings);
        if (err_cnt == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // watchdog
    initial begin
        #3000000;
        $display("FAIL");
        $finish;
    end

endmodule
